/* rtl/cscan_pkg.sv */
// ----------------------------------------------------------------------------
// cscan_pkg
// Types and constants shared by the token scanner modules.
// ----------------------------------------------------------------------------
package cscan_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_SLASH = 4'd1,
      MODE_LINEC = 4'd2,
      MODE_BLOCK = 4'd3,
      MODE_BSTAR = 4'd4,
      MODE_IDENT = 4'd5,
      MODE_NUM   = 4'd6,
      MODE_QUOTE = 4'd7,
      MODE_QESC  = 4'd8,
      MODE_EQ    = 4'd9,
      MODE_EQGT  = 4'd10,
      MODE_COLON = 4'd11
   } mode_type;

   localparam logic [4:0] KIND_END    = 5'd0;
   localparam logic [4:0] KIND_IDENT  = 5'd1;
   localparam logic [4:0] KIND_NUMBER = 5'd2;
   localparam logic [4:0] KIND_STRING = 5'd3;
   localparam logic [4:0] KIND_CHAR   = 5'd4;
   localparam logic [4:0] KIND_LBRACE = 5'd5;
   localparam logic [4:0] KIND_RBRACE = 5'd6;
   localparam logic [4:0] KIND_LPAREN = 5'd7;
   localparam logic [4:0] KIND_RPAREN = 5'd8;
   localparam logic [4:0] KIND_LBRACK = 5'd9;
   localparam logic [4:0] KIND_RBRACK = 5'd10;
   localparam logic [4:0] KIND_SEMI   = 5'd11;
   localparam logic [4:0] KIND_COMMA  = 5'd12;
   localparam logic [4:0] KIND_DOT    = 5'd13;
   localparam logic [4:0] KIND_LT     = 5'd14;
   localparam logic [4:0] KIND_GT     = 5'd15;
   localparam logic [4:0] KIND_ARROW  = 5'd16;
   localparam logic [4:0] KIND_ARROW2 = 5'd17;
   localparam logic [4:0] KIND_SCOPE  = 5'd18;
   localparam logic [4:0] KIND_COLON  = 5'd19;
   localparam logic [4:0] KIND_OTHER  = 5'd20;

   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_EQ     = 8'h3D;

   localparam int SKIP_BITS = 16;

   // Byte classification from the front end to the scanner.
   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
      logic       is_space;
      logic       is_alpha;
      logic       is_digit;
      logic [4:0] punct_kind;
   } class_type;

   function automatic logic [4:0] punct_of(input logic [7:0] b);
      logic [4:0] k;
      begin
         unique case (b)
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            8'h3B:   k = KIND_SEMI;
            8'h2C:   k = KIND_COMMA;
            CH_DOT:  k = KIND_DOT;
            8'h3C:   k = KIND_LT;
            CH_GT:   k = KIND_GT;
            default: k = KIND_OTHER;
         endcase
         return k;
      end
   endfunction

endpackage

/* rtl/cscan_front.sv */
// ----------------------------------------------------------------------------
// cscan_front
// Accept text bytes, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module cscan_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   output logic                  q_valid,
   input  logic                  q_take,
   output cscan_pkg::class_type  q_item
);
   cscan_pkg::class_type slot_ff [2];
   cscan_pkg::class_type slot_in;
   logic       rd_ff, wr_ff, rd_in, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   always_comb begin
      slot_in.ch         = req_tdata;
      slot_in.is_end     = (req_tdata == 8'd0);
      slot_in.is_space   = (req_tdata == 8'h20) ||
                           (req_tdata >= 8'h09 && req_tdata <= 8'h0D);
      slot_in.is_alpha   = (req_tdata >= 8'h61 && req_tdata <= 8'h7A) ||
                           (req_tdata >= 8'h41 && req_tdata <= 8'h5A);
      slot_in.is_digit   = (req_tdata >= 8'h30 && req_tdata <= 8'h39);
      slot_in.punct_kind = cscan_pkg::punct_of(req_tdata);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push   = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop    = q_valid && q_take;
   assign q_item = slot_ff[rd_ff];
   assign rd_in  = rd_ff ^ pop;
   assign wr_in  = wr_ff ^ push;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= slot_in;
      end
   end
endmodule

/* rtl/cscan_back.sv */
// ----------------------------------------------------------------------------
// cscan_back
// Scan classified bytes, track position and emit up to two tokens per byte.
// ----------------------------------------------------------------------------
module cscan_back #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 12,
   parameter int LENGTH_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  cscan_pkg::class_type  q_item,
   output logic                  tok_valid,
   input  logic                  tok_ready,
   output logic [4:0]            tok_kind,
   output logic [LINE_BITS-1:0]  tok_line,
   output logic [COLUMN_BITS-1:0] tok_column,
   output logic [OFFSET_BITS-1:0] tok_offset,
   output logic [LENGTH_BITS-1:0] tok_length,
   output logic [cscan_pkg::SKIP_BITS-1:0] tok_space,
   output logic                  tok_last
);
   localparam int SB = cscan_pkg::SKIP_BITS;
   localparam int TW = 5 + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LENGTH_BITS + SB + 1;
   localparam logic [OFFSET_BITS-1:0] OMAX = '1;
   localparam logic [LINE_BITS-1:0]   LMAX = '1;
   localparam logic [COLUMN_BITS-1:0] CMAX = '1;
   localparam logic [LENGTH_BITS-1:0] NMAX = '1;
   localparam logic [SB-1:0]          SMAX = '1;

   cscan_pkg::mode_type mode_ff, mode_in;
   logic                  dq_ff, dq_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, so_ff, so_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, sl_ff, sl_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, sc_ff, sc_in;
   logic [SB-1:0]          skip_ff, skip_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   // Output buffer: two slots hold the tokens of one byte.
   logic [TW-1:0] ob_ff [2];
   logic [1:0]    ocnt_ff;
   logic          ohead_ff;
   logic [TW-1:0] t0, t1;
   logic          e0, e1;

   logic [LENGTH_BITS-1:0] len_inc;
   logic [SB-1:0]          skip_inc, skip_inc2;
   logic [7:0] b;
   logic       rescan, do_step;
   logic [4:0] fk, k0, k1;
   logic [LENGTH_BITS-1:0] l0, l1;
   logic [SB-1:0]          s0, s1;
   logic [LINE_BITS-1:0]   sl1;
   logic [COLUMN_BITS-1:0] sc1;
   logic [OFFSET_BITS-1:0] so1;
   logic       last1;

   assign b         = q_item.ch;
   assign len_inc   = (len_ff == NMAX) ? NMAX : len_ff + 1'b1;
   assign skip_inc  = (skip_ff == SMAX) ? SMAX : skip_ff + 1'b1;
   assign skip_inc2 = (skip_inc == SMAX) ? SMAX : skip_inc + 1'b1;
   assign q_take    = (ocnt_ff == 2'd0) || (ocnt_ff == 2'd1 && tok_ready);
   assign do_step   = q_valid && q_take;

   // Kind of the open token on a flush.
   always_comb begin
      unique case (mode_ff)
         cscan_pkg::MODE_IDENT: fk = cscan_pkg::KIND_IDENT;
         cscan_pkg::MODE_NUM:   fk = cscan_pkg::KIND_NUMBER;
         cscan_pkg::MODE_QUOTE,
         cscan_pkg::MODE_QESC:  fk = dq_ff ? cscan_pkg::KIND_STRING : cscan_pkg::KIND_CHAR;
         cscan_pkg::MODE_EQGT:  fk = cscan_pkg::KIND_ARROW;
         cscan_pkg::MODE_COLON: fk = cscan_pkg::KIND_COLON;
         default:               fk = cscan_pkg::KIND_OTHER;
      endcase
   end

   always_comb begin
      logic open;
      open = (mode_ff == cscan_pkg::MODE_SLASH) || (mode_ff == cscan_pkg::MODE_IDENT) ||
             (mode_ff == cscan_pkg::MODE_NUM) || (mode_ff == cscan_pkg::MODE_QUOTE) ||
             (mode_ff == cscan_pkg::MODE_QESC) || (mode_ff == cscan_pkg::MODE_EQ) ||
             (mode_ff == cscan_pkg::MODE_EQGT) || (mode_ff == cscan_pkg::MODE_COLON);
      mode_in = mode_ff; dq_in = dq_ff; len_in = len_ff; skip_in = skip_ff;
      sl_in = sl_ff; sc_in = sc_ff; so_in = so_ff;
      pos_in = (pos_ff == OMAX) ? OMAX : pos_ff + 1'b1;
      line_in = line_ff;
      col_in  = (col_ff == CMAX) ? CMAX : col_ff + 1'b1;
      if (b == cscan_pkg::CH_NL) begin
         line_in = (line_ff == LMAX) ? LMAX : line_ff + 1'b1;
         col_in  = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
      end
      e0 = 1'b0; k0 = fk; l0 = len_ff; s0 = skip_ff;
      e1 = 1'b0; k1 = cscan_pkg::KIND_OTHER; l1 = len_ff; s1 = skip_ff;
      sl1 = sl_ff; sc1 = sc_ff; so1 = so_ff;
      rescan = 1'b0;
      if (q_item.is_end) begin
         e0 = open;
         e1 = 1'b1; k1 = cscan_pkg::KIND_END; l1 = '0;
         s1 = open ? '0 : skip_ff;
         sl1 = line_ff; sc1 = col_ff; so1 = pos_ff;
         mode_in = cscan_pkg::MODE_IDLE; dq_in = 1'b0;
         pos_in = '0; line_in = {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_in = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         so_in = '0; sl_in = {{(LINE_BITS-1){1'b0}}, 1'b1};
         sc_in = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         skip_in = '0; len_in = '0;
      end else begin
         unique case (mode_ff)
            cscan_pkg::MODE_SLASH: begin
               if (b == cscan_pkg::CH_SLASH || b == cscan_pkg::CH_STAR) begin
                  mode_in = (b == cscan_pkg::CH_SLASH) ? cscan_pkg::MODE_LINEC
                                                       : cscan_pkg::MODE_BLOCK;
                  skip_in = skip_inc2;
               end else begin
                  e0 = 1'b1; rescan = 1'b1;
               end
            end
            cscan_pkg::MODE_LINEC: begin
               if (b == cscan_pkg::CH_NL) mode_in = cscan_pkg::MODE_IDLE;
               skip_in = skip_inc;
            end
            cscan_pkg::MODE_BLOCK: begin
               if (b == cscan_pkg::CH_STAR) mode_in = cscan_pkg::MODE_BSTAR;
               skip_in = skip_inc;
            end
            cscan_pkg::MODE_BSTAR: begin
               if (b == cscan_pkg::CH_SLASH) mode_in = cscan_pkg::MODE_IDLE;
               else if (b != cscan_pkg::CH_STAR) mode_in = cscan_pkg::MODE_BLOCK;
               skip_in = skip_inc;
            end
            cscan_pkg::MODE_IDENT, cscan_pkg::MODE_NUM: begin
               if (q_item.is_alpha || q_item.is_digit || b == cscan_pkg::CH_UNDER ||
                   (mode_ff == cscan_pkg::MODE_NUM && b == cscan_pkg::CH_DOT)) begin
                  len_in = len_inc;
               end else begin
                  e0 = 1'b1; rescan = 1'b1;
               end
            end
            cscan_pkg::MODE_QUOTE: begin
               len_in = len_inc;
               if (b == cscan_pkg::CH_BSLASH) begin
                  mode_in = cscan_pkg::MODE_QESC;
               end else if (b == (dq_ff ? cscan_pkg::CH_DQUOTE : cscan_pkg::CH_SQUOTE)) begin
                  e0 = 1'b1; l0 = len_inc; mode_in = cscan_pkg::MODE_IDLE; skip_in = '0;
               end
            end
            cscan_pkg::MODE_QESC: begin
               len_in = len_inc; mode_in = cscan_pkg::MODE_QUOTE;
            end
            cscan_pkg::MODE_EQ: begin
               if (b == cscan_pkg::CH_GT) begin
                  len_in = len_inc; mode_in = cscan_pkg::MODE_EQGT;
               end else begin
                  e0 = 1'b1; rescan = 1'b1;
               end
            end
            cscan_pkg::MODE_EQGT, cscan_pkg::MODE_COLON: begin
               if ((mode_ff == cscan_pkg::MODE_EQGT && b == cscan_pkg::CH_GT) ||
                   (mode_ff == cscan_pkg::MODE_COLON && b == cscan_pkg::CH_COLON)) begin
                  e0 = 1'b1; l0 = len_inc;
                  k0 = (mode_ff == cscan_pkg::MODE_EQGT) ? cscan_pkg::KIND_ARROW2
                                                         : cscan_pkg::KIND_SCOPE;
                  mode_in = cscan_pkg::MODE_IDLE; skip_in = '0;
               end else begin
                  e0 = 1'b1; rescan = 1'b1;
               end
            end
            default: begin
               mode_in = cscan_pkg::MODE_IDLE; rescan = 1'b1;
            end
         endcase
         if (rescan) begin
            mode_in = cscan_pkg::MODE_IDLE;
            s1 = e0 ? '0 : skip_ff;
            skip_in = s1;
            if (q_item.is_space) begin
               skip_in = (s1 == SMAX) ? SMAX : s1 + 1'b1;
            end else begin
               sl_in = line_ff; sc_in = col_ff; so_in = pos_ff;
               sl1 = line_ff; sc1 = col_ff; so1 = pos_ff;
               len_in = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               l1 = len_in;
               if (b == cscan_pkg::CH_SLASH) mode_in = cscan_pkg::MODE_SLASH;
               else if (q_item.is_alpha || b == cscan_pkg::CH_UNDER)
                  mode_in = cscan_pkg::MODE_IDENT;
               else if (q_item.is_digit) mode_in = cscan_pkg::MODE_NUM;
               else if (b == cscan_pkg::CH_DQUOTE || b == cscan_pkg::CH_SQUOTE) begin
                  mode_in = cscan_pkg::MODE_QUOTE;
                  dq_in = (b == cscan_pkg::CH_DQUOTE);
               end else if (b == cscan_pkg::CH_EQ) mode_in = cscan_pkg::MODE_EQ;
               else if (b == cscan_pkg::CH_COLON) mode_in = cscan_pkg::MODE_COLON;
               else begin
                  e1 = 1'b1; k1 = q_item.punct_kind; skip_in = '0;
               end
            end
         end
      end
      last1 = 1'b1;
      t0 = {k0, sl_ff, sc_ff, so_ff, l0, s0, !e1};
      t1 = {k1, sl1, sc1, so1, l1, s1, last1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cscan_pkg::MODE_IDLE;
         dq_ff   <= 1'b0;
         pos_ff  <= '0;
         line_ff <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_ff  <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         so_ff   <= '0;
         sl_ff   <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         sc_ff   <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         skip_ff <= '0;
         len_ff  <= '0;
      end else if (do_step) begin
         mode_ff <= mode_in; dq_ff <= dq_in; pos_ff <= pos_in;
         line_ff <= line_in; col_ff <= col_in; so_ff <= so_in;
         sl_ff <= sl_in; sc_ff <= sc_in; skip_ff <= skip_in; len_ff <= len_in;
      end
   end

   // Output slots: head at ohead_ff, load the byte's tokens in order.
   logic [1:0] ocnt_in;
   logic       ohead_in;
   always_comb begin
      ocnt_in = ocnt_ff; ohead_in = ohead_ff;
      if (tok_valid && tok_ready) begin
         ocnt_in = ocnt_ff - 2'd1; ohead_in = !ohead_ff;
      end
      if (do_step) begin
         ocnt_in = ocnt_in + {1'b0, e0} + {1'b0, e1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff  <= 2'd0;
         ohead_ff <= 1'b0;
      end else begin
         ocnt_ff  <= ocnt_in;
         ohead_ff <= ohead_in;
      end
   end

   // A step only happens with the slots empty after this cycle's pop, so the
   // first new token always lands at the new head.
   always_ff @(posedge clock) begin
      if (do_step) begin
         if (e0 && e1) begin
            ob_ff[ohead_in]  <= t0;
            ob_ff[!ohead_in] <= t1;
         end else if (e0) begin
            ob_ff[ohead_in] <= t0;
         end else if (e1) begin
            ob_ff[ohead_in] <= t1;
         end
      end
   end

   assign tok_valid = (ocnt_ff != 2'd0);
   assign {tok_kind, tok_line, tok_column, tok_offset, tok_length, tok_space, tok_last} =
          ob_ff[ohead_ff];
endmodule

/* rtl/c_style_token_scanner.sv */
// ----------------------------------------------------------------------------
// c_style_token_scanner
// Streaming C-style tokenizer: one text byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one source byte per item; a zero byte ends the text,
//    flushes any open token, emits an end token and resets position to the
//    first line, first column, offset zero.
//  - rsp_ channel carries one token per item; rsp_tlast marks the last token
//    caused by an input byte.
//  - A front stage classifies bytes into a two-entry queue; the scanner
//    behind it consumes one byte a cycle whenever its output slots are empty
//    or drain in that cycle, so with the receiver ready a byte that yields
//    at most one token keeps a rate of one byte per clock. A byte yielding two
//    tokens holds the scanner back while both output slots are full.
//  - Bytes are registered in the front queue and tokens in an output slot.
//  - When the receiver stalls, hold tokens in the output slots; the queue
//    then fills and req_tready drops.
//  - reset clears mode, counters and both queues.
// ----------------------------------------------------------------------------
module c_style_token_scanner #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 12,
   parameter int LENGTH_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // token_kind, token_line, token_column, token_offset, token_length,
   // space_length, from the lowest bit up, zero-filled to whole bytes
   output logic [((5 + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LENGTH_BITS + 16 + 7) / 8) * 8 - 1:0]
                      rsp_tdata,
   output logic       rsp_tlast
);
   localparam int DW = 5 + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LENGTH_BITS + 16;
   localparam int PW = ((DW + 7) / 8) * 8;

   cscan_pkg::class_type q_item;
   logic q_valid, q_take;
   logic [4:0]             kind;
   logic [LINE_BITS-1:0]   line;
   logic [COLUMN_BITS-1:0] col;
   logic [OFFSET_BITS-1:0] offs;
   logic [LENGTH_BITS-1:0] len;
   logic [15:0]            space;

   // Accept and classify bytes.
   cscan_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_take, .q_item
   );

   // Scan and emit tokens.
   cscan_back #(
      .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS),
      .COLUMN_BITS(COLUMN_BITS), .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item,
      .tok_valid(rsp_tvalid), .tok_ready(rsp_tready),
      .tok_kind(kind), .tok_line(line), .tok_column(col), .tok_offset(offs),
      .tok_length(len), .tok_space(space), .tok_last(rsp_tlast)
   );

   assign rsp_tdata = {{(PW-DW){1'b0}}, space, len, offs, col, line, kind};
endmodule
